[rtl/mcfp_pkg.sv]
// Shared types and constants of the mesh chat frame parser.
`default_nettype none
package mcfp_pkg;
    localparam int PEER_ID_BYTES_DEF   = 8;
    localparam int SIGNATURE_BYTES_DEF = 64;
    localparam int LENGTH_BITS_DEF     = 20;

    localparam logic [3:0] SEC_VERSION = 4'd0;
    localparam logic [3:0] SEC_TYPE    = 4'd1;
    localparam logic [3:0] SEC_TTL     = 4'd2;
    localparam logic [3:0] SEC_TIME    = 4'd3;
    localparam logic [3:0] SEC_FLAGS   = 4'd4;
    localparam logic [3:0] SEC_LENGTH  = 4'd5;
    localparam logic [3:0] SEC_SENDER  = 4'd6;
    localparam logic [3:0] SEC_RECIP   = 4'd7;
    localparam logic [3:0] SEC_HOPCNT  = 4'd8;
    localparam logic [3:0] SEC_HOP     = 4'd9;
    localparam logic [3:0] SEC_ORIG    = 4'd10;
    localparam logic [3:0] SEC_PAYLOAD = 4'd11;
    localparam logic [3:0] SEC_SIG     = 4'd12;
    localparam logic [3:0] SEC_TRAIL   = 4'd13;
    localparam logic [3:0] SEC_DISCARD = 4'd14;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_VERSION = 3'd1;
    localparam logic [2:0] ST_TOOBIG  = 3'd2;
    localparam logic [2:0] ST_HOPS    = 3'd3;
    localparam logic [2:0] ST_COMPLEN = 3'd4;
    localparam logic [2:0] ST_RATIO   = 3'd5;
    localparam logic [2:0] ST_TRUNC   = 3'd6;

    localparam int F_RECIP = 0;
    localparam int F_SIG   = 1;
    localparam int F_COMP  = 2;
    localparam int F_ROUTE = 3;

    localparam logic [15:0] RATIO_LIMIT_P1 = 16'd50001;

    localparam logic [0:0] CFG_MAX_PAYLOAD = 1'b0;
    localparam logic [0:0] CFG_MAX_HOPS    = 1'b1;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       ver_ok;
        logic       ver_two;
        logic       hop_over;
    } t_item;
endpackage
`default_nettype wire

[rtl/mesh_chat_frame_parser.sv]
// Top level of the mesh chat frame parser.
//  channel  | dir | handshake                    | payload
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata byte_value, tlast frame_end
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata section..status, tuser, tlast
//  cfg      | in  | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
// One byte per cycle while m_axis accepts; an accepted byte passes through a queue entry
// and then the output register.
// The byte parser updates its frame state once per byte.
// Reset is synchronous; it empties the two-entry queue and the output register.
// When m_axis stalls the queue still takes one more byte and s_axis_tready drops once the queue is full.
`default_nettype none
module mesh_chat_frame_parser
    import mcfp_pkg::*;
#(
    parameter int PEER_ID_BYTES   = PEER_ID_BYTES_DEF,
    parameter int SIGNATURE_BYTES = SIGNATURE_BYTES_DEF,
    parameter int LENGTH_BITS     = LENGTH_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [3:0] section, [23:4] offset, [31:24] value,
                                             // [34:32] status, [39:35] zero
    output logic [0:0]       m_axis_tuser,   // [0] compressed
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [19:0] i_cfg_data
);
    logic [19:0] r_max_payload;
    logic [7:0]  r_max_hops;
    logic        w_q_valid, w_pop;
    t_item       w_item;
    logic [3:0]  w_section;
    logic [19:0] w_offset;
    logic [7:0]  w_value;
    logic        w_comp;
    logic [2:0]  w_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= 20'hFFFFF;
            r_max_hops    <= 8'd16;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data;
                CFG_MAX_HOPS:    r_max_hops    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    mcfp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_value    (s_axis_tdata),
        .i_last     (s_axis_tlast),
        .i_max_hops (r_max_hops),
        .o_valid    (w_q_valid),
        .i_pop      (w_pop),
        .o_item     (w_item)
    );

    mcfp_back #(
        .PEER_ID_BYTES   (PEER_ID_BYTES),
        .SIGNATURE_BYTES (SIGNATURE_BYTES),
        .LENGTH_BITS     (LENGTH_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_q_valid),
        .i_item        (w_item),
        .o_pop         (w_pop),
        .i_max_payload (r_max_payload),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_section     (w_section),
        .o_offset      (w_offset),
        .o_value       (w_value),
        .o_compressed  (w_comp),
        .o_last        (m_axis_tlast),
        .o_status      (w_status)
    );

    assign m_axis_tdata = {5'd0, w_status, w_value, w_offset, w_section};
    assign m_axis_tuser = w_comp;
endmodule
`default_nettype wire

[rtl/mcfp_front.sv]
// Front end: classify each request byte and queue it for the parser.
`default_nettype none
module mcfp_front
    import mcfp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_value,
    input  wire logic       i_last,
    input  wire logic [7:0] i_max_hops,
    output logic            o_valid,
    input  wire logic       i_pop,
    output t_item           o_item
);
    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_push;

    always_comb begin
        w_item.value    = i_value;
        w_item.last     = i_last;
        w_item.ver_ok   = (i_value == 8'd1) || (i_value == 8'd2);
        w_item.ver_two  = (i_value == 8'd2);
        w_item.hop_over = (i_value > i_max_hops);
    end

    assign o_ready = (r_cnt != 2'd2);
    assign w_push  = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

[rtl/mcfp_back.sv]
// Back end: frame section tracking, checks and the output register.
`default_nettype none
module mcfp_back
    import mcfp_pkg::*;
#(
    parameter int PEER_ID_BYTES   = PEER_ID_BYTES_DEF,
    parameter int SIGNATURE_BYTES = SIGNATURE_BYTES_DEF,
    parameter int LENGTH_BITS     = LENGTH_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_item       i_item,
    output logic             o_pop,
    input  wire logic [19:0] i_max_payload,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_section,
    output logic [19:0]      o_offset,
    output logic [7:0]       o_value,
    output logic             o_compressed,
    output logic             o_last,
    output logic [2:0]       o_status
);
    localparam int LB = LENGTH_BITS;

    logic [3:0]    r_phase, n_phase;
    logic [LB-1:0] r_cnt, n_cnt;
    logic          r_v2, n_v2;
    logic [4:0]    r_flags, n_flags;
    logic [31:0]   r_len, n_len;
    logic [31:0]   r_orig, n_orig;
    logic [7:0]    r_hops, n_hops;
    logic [2:0]    r_err, n_err;
    logic [35:0]   r_prod;
    logic [19:0]   w_csize;
    logic [2:0]    w_lb;
    logic [31:0]   w_size;
    logic [LB-1:0] w_inc;
    logic [3:0]    w_p;
    logic [3:0]    w_sec;
    logic [19:0]   w_off;
    logic [2:0]    w_status;

    function automatic logic [3:0] f_next(input logic [3:0] p, input logic [4:0] fl,
                                          input logic v2);
        logic [3:0] q;
        q = p + 4'd1;
        case (p)
            SEC_SENDER: begin
                if (fl[F_RECIP]) q = SEC_RECIP;
                else if (v2 && fl[F_ROUTE]) q = SEC_HOPCNT;
                else if (fl[F_COMP]) q = SEC_ORIG;
                else q = SEC_PAYLOAD;
            end
            SEC_RECIP: begin
                if (v2 && fl[F_ROUTE]) q = SEC_HOPCNT;
                else if (fl[F_COMP]) q = SEC_ORIG;
                else q = SEC_PAYLOAD;
            end
            SEC_HOP:     q = fl[F_COMP] ? SEC_ORIG : SEC_PAYLOAD;
            SEC_HOPCNT:  q = SEC_HOP;
            SEC_ORIG:    q = SEC_PAYLOAD;
            SEC_PAYLOAD: q = fl[F_SIG] ? SEC_SIG : SEC_TRAIL;
            SEC_SIG:     q = SEC_TRAIL;
            default:     q = p + 4'd1;
        endcase
        return q;
    endfunction

    assign o_pop   = i_valid && (!o_valid || i_ready);
    assign w_lb    = r_v2 ? 3'd4 : 3'd2;
    assign w_csize = r_len[19:0] - {17'd0, w_lb};

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_v2    = r_v2;
        n_flags = r_flags;
        n_len   = r_len;
        n_orig  = r_orig;
        n_hops  = r_hops;
        n_err   = r_err;
        w_sec   = r_phase;
        w_off   = 20'd0;
        w_size  = 32'd1;
        w_inc   = r_cnt + {{(LB-1){1'b0}}, 1'b1};
        w_p     = r_phase;
        if (r_phase == SEC_TRAIL) begin
            w_off = 20'(32'(r_cnt));
            if (r_cnt != {LB{1'b1}}) n_cnt = w_inc;
        end else if (r_phase != SEC_DISCARD) begin
            w_off = 20'(32'(r_cnt));
            case (r_phase)
                SEC_VERSION: begin
                    n_v2 = i_item.ver_two;
                    if (!i_item.ver_ok) n_err = ST_VERSION;
                end
                SEC_FLAGS:  n_flags = i_item.value[4:0];
                SEC_LENGTH: n_len = {r_len[23:0], i_item.value};
                SEC_ORIG:   n_orig = {r_orig[23:0], i_item.value};
                SEC_HOPCNT: begin
                    n_hops = i_item.value;
                    if (i_item.hop_over) n_err = ST_HOPS;
                end
                default: ;
            endcase
            case (r_phase)
                SEC_TIME:              w_size = 32'd8;
                SEC_LENGTH, SEC_ORIG:  w_size = {29'd0, (n_v2 ? 3'd4 : 3'd2)};
                SEC_SENDER, SEC_RECIP,
                SEC_HOP:               w_size = 32'(PEER_ID_BYTES);
                SEC_PAYLOAD:           w_size = n_flags[F_COMP] ? n_len - {29'd0, w_lb}
                                                                : n_len;
                SEC_SIG:               w_size = 32'(SIGNATURE_BYTES);
                default:               w_size = 32'd1;
            endcase
            n_cnt = w_inc;
            if (n_err == ST_OK && w_inc == w_size[LB-1:0]) begin
                if (r_phase == SEC_LENGTH && n_len > {12'd0, i_max_payload}) begin
                    n_err = ST_TOOBIG;
                end else if (r_phase == SEC_HOP && r_hops > 8'd1) begin
                    n_hops = r_hops - 8'd1;
                    n_cnt  = '0;
                end else begin
                    if (r_phase == SEC_HOP) n_hops = 8'd0;
                    w_p = f_next(r_phase, n_flags, n_v2);
                    if (w_p == SEC_HOP && n_hops == 8'd0) w_p = f_next(SEC_HOP, n_flags, n_v2);
                    if (w_p == SEC_ORIG && n_len < {29'd0, w_lb}) begin
                        n_err = ST_COMPLEN;
                    end else if (w_p == SEC_PAYLOAD && n_flags[F_COMP]) begin
                        if (n_orig > {12'd0, i_max_payload}) n_err = ST_TOOBIG;
                        else if (n_orig == 32'd0 || n_len == {29'd0, w_lb}) n_err = ST_COMPLEN;
                        else if ({4'd0, n_orig} >= r_prod) n_err = ST_RATIO;
                    end else if (w_p == SEC_PAYLOAD && n_len == 32'd0) begin
                        w_p = f_next(SEC_PAYLOAD, n_flags, n_v2);
                    end
                    if (n_err == ST_OK) begin
                        n_phase = w_p;
                        n_cnt   = '0;
                    end
                end
            end
            if (n_err != ST_OK) n_phase = SEC_DISCARD;
        end
        w_status = ST_OK;
        if (i_item.last) begin
            if (n_err != ST_OK) w_status = n_err;
            else if (n_phase != SEC_TRAIL) w_status = ST_TRUNC;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_csize * RATIO_LIMIT_P1;
        if (o_pop) begin
            o_section    <= w_sec;
            o_offset     <= w_off;
            o_value      <= i_item.value;
            o_compressed <= n_flags[F_COMP];
            o_last       <= i_item.last;
            o_status     <= w_status;
        end
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_phase <= SEC_VERSION;
            r_cnt   <= '0;
            r_v2    <= 1'b0;
            r_flags <= 5'd0;
            r_len   <= 32'd0;
            r_orig  <= 32'd0;
            r_hops  <= 8'd0;
            r_err   <= ST_OK;
        end else begin
            if (o_pop) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
            if (o_pop) begin
                if (i_item.last) begin
                    r_phase <= SEC_VERSION;
                    r_cnt   <= '0;
                    r_v2    <= 1'b0;
                    r_flags <= 5'd0;
                    r_len   <= 32'd0;
                    r_orig  <= 32'd0;
                    r_hops  <= 8'd0;
                    r_err   <= ST_OK;
                end else begin
                    r_phase <= n_phase;
                    r_cnt   <= n_cnt;
                    r_v2    <= n_v2;
                    r_flags <= n_flags;
                    r_len   <= n_len;
                    r_orig  <= n_orig;
                    r_hops  <= n_hops;
                    r_err   <= n_err;
                end
            end
        end
    end
endmodule
`default_nettype wire

[rtl/mcfp_checker.sv]
// Port-level checks of the mesh chat frame parser, bound to the top level.
`default_nettype none
module mcfp_checker
    import mcfp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[34:32] == ST_OK)
        else $error("status outside final byte");
    a_section: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] != 4'd15)
        else $error("section code out of range");
    a_discard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3:0] == SEC_DISCARD |-> m_axis_tdata[23:4] == 20'd0)
        else $error("discarded byte with offset");
endmodule

bind mesh_chat_frame_parser mcfp_checker u_mcfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
